/* hdl/lvr_pkg.sv */
// ----------------------------------------------------------------------------
// lvr_pkg: shared types and constants of the low-variance resampler
// Widths of the cumulative sums, the products and the payload structs.
// ----------------------------------------------------------------------------
package lvr_pkg;

	localparam int MAX_PARTICLES = 1024;
	localparam int IDX_W = $clog2(MAX_PARTICLES);
	localparam int CNT_W = 11;
	localparam int WEIGHT_W = 32;
	localparam int OFFSET_W = 16;
	localparam int SUM_W = WEIGHT_W + IDX_W;
	localparam int SUM_LO_W = SUM_W / 2;
	localparam int SUM_HI_W = SUM_W - SUM_LO_W;
	localparam int U_W = CNT_W + OFFSET_W;
	localparam int PART_W = U_W + SUM_HI_W;
	localparam int LHS_W = U_W + SUM_W;
	localparam int RHS_W = CNT_W + SUM_W;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1000;

	typedef enum logic [0:0] {
		KIND_LOAD = 1'b0,
		KIND_DRAW = 1'b1
	} kind_t;

	typedef enum logic [0:0] {
		REG_PARTICLE_COUNT = 1'b0,
		REG_NONE = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROD,
		S_SUM,
		S_READ,
		S_MUL,
		S_CMP,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [0:0] kind;
		logic [WEIGHT_W-1:0] weight;
		logic [OFFSET_W-1:0] offset;
	} in_item_t;

	typedef struct packed {
		logic [9:0] parent_index;
		logic last_draw;
		logic zero_total;
	} out_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] count_eff;
	} cfg_t;

	typedef struct packed {
		logic res_valid;
		logic out_free;
	} res_ctl_t;

endpackage

/* hdl/lvr_if.sv */
// ----------------------------------------------------------------------------
// lvr_if: valid/ready channels of the low-variance resampler
// One interface for input items and one for result items.
// ----------------------------------------------------------------------------
interface lvr_in_if;
	import lvr_pkg::*;
	logic valid;
	logic ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lvr_out_if;
	import lvr_pkg::*;
	logic valid;
	logic ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/lvr_ram.sv */
// ----------------------------------------------------------------------------
// lvr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lvr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/lvr_cfg.sv */
// ----------------------------------------------------------------------------
// lvr_cfg: APB register of the low-variance resampler
// Holds particle_count and presents it clamped to 1..MAX_PARTICLES.
// ----------------------------------------------------------------------------
module lvr_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lvr_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [lvr_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [lvr_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                              pready,
	output lvr_pkg::cfg_t                     cfg
);
	import lvr_pkg::*;

	logic [CNT_W-1:0] count_q;
	reg_idx_t sel_reg;
	logic wr_en;

	assign pready = 1'b1;
	assign sel_reg = reg_idx_t'(paddr[CFG_ADDR_W-1]);
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (wr_en && sel_reg == REG_PARTICLE_COUNT) begin
			count_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		unique case (sel_reg)
			REG_PARTICLE_COUNT: prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, count_q};
			default:            prdata = '0;
		endcase
	end

	// A count of zero acts as one; counts above the table size act as its size.
	always_comb begin
		if (count_q == '0) begin
			cfg.count_eff = CNT_W'(1);
		end else if (count_q > CNT_W'(MAX_PARTICLES)) begin
			cfg.count_eff = CNT_W'(MAX_PARTICLES);
		end else begin
			cfg.count_eff = count_q;
		end
	end

endmodule

/* hdl/lvr_core.sv */
// ----------------------------------------------------------------------------
// lvr_core: cumulative-sum store and index walk
// Builds the cumulative table on loads and walks it on draws.
// ----------------------------------------------------------------------------
module lvr_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lvr_pkg::cfg_t        cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lvr_pkg::in_item_t    in_data,
	input  logic                 out_free,
	output logic                 res_valid,
	output lvr_pkg::out_item_t   res_data
);
	import lvr_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]    loaded_q;
	logic [SUM_W-1:0]    total_q;
	logic [CNT_W-1:0]    draw_q;
	logic [IDX_W-1:0]    walk_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [U_W-1:0]      u_q;
	logic [PART_W-1:0]   plo_q, phi_q;
	logic [LHS_W-1:0]    lhs_q;
	logic [RHS_W-1:0]    rhs_q;
	logic                last_q, zero_q;

	logic [CNT_W-1:0]    n;
	logic                accept, load_acc, draw_acc, loaded_full;
	logic                restart;
	logic [CNT_W-1:0]    load_idx;
	logic [SUM_W-1:0]    load_sum;
	logic [OFFSET_W-1:0] offset_eff;
	logic [CNT_W-1:0]    draw_inc;
	logic                walk_ok, step_more;
	logic                ram_re;
	logic [SUM_W-1:0]    ram_rdata;

	assign n = cfg.count_eff;
	assign accept = in_valid && in_ready;
	assign loaded_full = loaded_q >= n;
	assign load_acc = accept && kind_t'(in_data.kind) == KIND_LOAD;
	assign draw_acc = accept && kind_t'(in_data.kind) == KIND_DRAW && loaded_full;

	assign restart = loaded_full;
	assign load_idx = restart ? '0 : loaded_q;
	assign load_sum = (restart ? '0 : total_q) + SUM_W'(in_data.weight);

	assign offset_eff = (draw_q == '0) ? in_data.offset : offset_q;
	assign draw_inc = draw_q + CNT_W'(1);

	assign walk_ok = ({1'b0, walk_q} + CNT_W'(1)) < n;
	assign step_more = lhs_q > {rhs_q, {OFFSET_W{1'b0}}};

	lvr_ram #(
		.WIDTH (SUM_W),
		.DEPTH (MAX_PARTICLES)
	) u_store (
		.clk   (clk),
		.we    (load_acc && load_idx < CNT_W'(MAX_PARTICLES)),
		.waddr (load_idx[IDX_W-1:0]),
		.wdata (load_sum),
		.re    (ram_re),
		.raddr (walk_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (draw_acc) begin
					state_d = (total_q == '0) ? S_OUT : S_PROD;
				end
			end
			S_PROD: state_d = S_SUM;
			S_SUM:  state_d = S_READ;
			S_READ: state_d = walk_ok ? S_MUL : S_OUT;
			S_MUL:  state_d = S_CMP;
			S_CMP:  state_d = step_more ? S_READ : S_OUT;
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		ram_re = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_READ: ram_re = walk_ok;
			S_OUT:  res_valid = 1'b1;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign res_data.parent_index = zero_q ? '0 : walk_q;
	assign res_data.last_draw = last_q;
	assign res_data.zero_total = zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			loaded_q <= '0;
			total_q  <= '0;
			draw_q   <= '0;
			walk_q   <= '0;
			offset_q <= '0;
		end else begin
			state_q <= state_d;
			if (load_acc) begin
				loaded_q <= load_idx + CNT_W'(1);
				total_q  <= load_sum;
				draw_q   <= '0;
				walk_q   <= '0;
			end else if (draw_acc) begin
				if (draw_q == '0) begin
					offset_q <= in_data.offset;
					walk_q   <= '0;
				end
				draw_q <= (draw_inc >= n) ? '0 : draw_inc;
			end else if (state_q == S_CMP && step_more) begin
				walk_q <= walk_q + IDX_W'(1);
			end
		end
	end

	// Arithmetic registers carry no reset.
	always_ff @(posedge clk) begin
		if (draw_acc) begin
			u_q    <= {draw_q, {OFFSET_W{1'b0}}} + U_W'(offset_eff);
			last_q <= draw_q == (n - CNT_W'(1));
			zero_q <= total_q == '0;
		end
		if (state_q == S_PROD) begin
			plo_q <= PART_W'(u_q) * PART_W'(total_q[SUM_LO_W-1:0]);
			phi_q <= PART_W'(u_q) * PART_W'(total_q[SUM_W-1:SUM_LO_W]);
		end
		if (state_q == S_SUM) begin
			lhs_q <= LHS_W'(plo_q) + {phi_q, {SUM_LO_W{1'b0}}};
		end
		if (state_q == S_MUL) begin
			rhs_q <= RHS_W'(n) * RHS_W'(ram_rdata);
		end
	end

endmodule

/* hdl/low_variance_resampler_unit.sv */
// ----------------------------------------------------------------------------
// low_variance_resampler_unit: systematic particle resampler
// Loads cumulative weights into a 1024-entry store and draws parent indices.
// ----------------------------------------------------------------------------
// Usage. Input items arrive on in_ch (valid/ready). A load item (kind 0)
// adds its Q0.32 weight to the running total and writes the cumulative sum
// to the next store entry of the current table and gives no result. After
// particle_count loads, each draw item (kind 1) gives one transfer on out_ch
// carrying parent_index, last_draw and zero_total. The first draw of a pass
// latches its Q0.16 offset. A draw before loading completes is taken and
// dropped. A load after a complete table starts a new table.
// Steps of a draw: the scaled position is multiplied by the total (partial
// products, then their sum), then each compare of the index walk takes a
// store read, a multiply by the count and a compare, or the walk ends when
// the index already sits at N-1; the result then goes into the output
// register. The walk index only moves forward within a pass. A zero total
// skips the walk and goes straight to the output state.
// The store read port sets the walk pace; one item is worked at a time.
// particle_count is written over the APB port at byte address 0 and resets
// to 1000. Reset clears all counters, the total and the output valid bit; the
// store itself is not cleared, as only entries of the current table are read.
// A stalled receiver holds the result in the output register; the block still
// accepts the next item and parks its result until the register frees up.
// ----------------------------------------------------------------------------
module low_variance_resampler_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	lvr_in_if.sink                            in_ch,
	lvr_out_if.source                         out_ch,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lvr_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [lvr_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [lvr_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                              pready
);
	import lvr_pkg::*;

	cfg_t      cfg;
	res_ctl_t  res_ctl;
	out_item_t res_data;
	out_item_t out_data_q;
	logic      out_valid_q;
	logic      core_ready;

	lvr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The output register is free when empty or when its transfer completes now.
	assign res_ctl.out_free = !out_valid_q || out_ch.ready;

	lvr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_ch.valid),
		.in_ready  (core_ready),
		.in_data   (in_ch.data),
		.out_free  (res_ctl.out_free),
		.res_valid (res_ctl.res_valid),
		.res_data  (res_data)
	);

	assign in_ch.ready = core_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ctl.out_free) begin
			out_valid_q <= res_ctl.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ctl.out_free && res_ctl.res_valid) begin
			out_data_q <= res_data;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_data_q;

	// A finished result that cannot move on is held by the core.
	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_ctl.res_valid && !res_ctl.out_free |=> res_ctl.res_valid)
		else $error("result dropped while output register busy");

	// The core never takes an item while it still holds a result.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		core_ready |-> !res_ctl.res_valid)
		else $error("input taken while a result is pending");

	// A void pass always reports parent zero.
	a_zero_parent: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.zero_total |-> out_ch.data.parent_index == '0)
		else $error("nonzero parent on zero total");

	// The output register is loaded only from a result that the core offered.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(res_ctl.res_valid))
		else $error("output valid without a core result");

endmodule
